// ----- rtl/tse_pkg.sv -----
// shared types and constants of the two-way timestamp sync engine
`default_nettype none

package tse_pkg;

  // event codes on the input channel
  typedef enum logic [2:0] {
    KIND_INIT        = 3'd0,
    KIND_TIME_QUERY  = 3'd1,
    KIND_TS_REQUEST  = 3'd2,
    KIND_TS_REPLY    = 3'd3,
    KIND_ADV_TICK    = 3'd4,
    KIND_SYNC_TMO    = 3'd5,
    KIND_ADVERT      = 3'd6,
    KIND_LEVEL_REPLY = 3'd7
  } kind_e;

  // result codes on the output channel
  typedef enum logic [3:0] {
    OK_TIME_ANSWER     = 4'd0,
    OK_ADVERT_BCAST    = 4'd1,
    OK_LEVEL_REPLY     = 4'd2,
    OK_SYNC_REQUEST    = 4'd3,
    OK_TS_REPLY        = 4'd4,
    OK_ADV_TIMER_START = 4'd5,
    OK_ADV_TIMER_STOP  = 4'd6,
    OK_SYNC_TIMER_START = 4'd7,
    OK_SYNC_TIMER_STOP = 4'd8
  } okind_e;

  // sync mode of the node
  typedef enum logic [1:0] {
    MODE_INIT         = 2'd0,
    MODE_SYNCED       = 2'd1,
    MODE_SYNCING      = 2'd2,
    MODE_INIT_SYNCING = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RESYNC_AFTER      = 3'd0,
    REG_LOCAL_WRAP_ADD    = 3'd1,
    REG_EXCHANGE_WRAP_ADD = 3'd2,
    REG_NOT_SYNCED_CODE   = 3'd3,
    REG_SYNC_TIMEOUT      = 3'd4,
    REG_ADV_PERIOD        = 3'd5,
    REG_SPARE6            = 3'd6,
    REG_SPARE7            = 3'd7
  } reg_e;

  localparam logic [15:0] BCAST_ADDR = 16'hFFFF;

  localparam logic [31:0] RST_RESYNC_AFTER      = 32'd30720;
  localparam logic [31:0] RST_LOCAL_WRAP_ADD    = 32'h7F00_0000;
  localparam logic [31:0] RST_EXCHANGE_WRAP_ADD = 32'h7FFF_FFFF;
  localparam logic [31:0] RST_NOT_SYNCED_CODE   = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_SYNC_TIMEOUT      = 16'd50;
  localparam logic [15:0] RST_ADV_PERIOD        = 16'd5120;

  localparam int MAX_RES = 3;

  // one input beat
  typedef struct packed {
    kind_e              kind;
    logic [31:0]        now;
    logic [31:0]        local_time;
    logic [15:0]        src_addr;
    logic [7:0]         seq_no;
    logic [31:0]        t1;
    logic [31:0]        t2;
    logic [31:0]        t3;
    logic [31:0]        t4;
    logic signed [7:0]  level_in;
  } in_item_t;

  // one output beat
  typedef struct packed {
    okind_e             out_kind;
    logic [15:0]        dest_addr;
    logic signed [7:0]  level_out;
    logic [7:0]         seq_out;
    logic [31:0]        global_time;
    logic [31:0]        refreshed;
    logic [31:0]        echo_first;
    logic [31:0]        echo_second;
    logic [15:0]        timer_period;
    logic               synced;
    logic               last;
  } out_item_t;

  // configuration registers
  typedef struct packed {
    logic [31:0] resync_after;
    logic [31:0] local_wrap_add;
    logic [31:0] exchange_wrap_add;
    logic [31:0] not_synced_code;
    logic [15:0] sync_timeout;
    logic [15:0] adv_period;
  } cfg_t;

  // protocol state
  typedef struct packed {
    mode_e              sync_mode;
    logic signed [7:0]  tree_level;
    logic [15:0]        parent_addr;
    logic [31:0]        clock_offset;
    logic [31:0]        last_sync_time;
    logic [7:0]         expected_seq;
  } node_state_t;

endpackage

`default_nettype wire

// ----- rtl/tse_step.sv -----
// event handler: next protocol state and up to three result beats for one event
`default_nettype none

module tse_step (
  input  tse_pkg::in_item_t          item_i,
  input  tse_pkg::node_state_t       state_i,
  input  tse_pkg::cfg_t              cfg_i,
  output tse_pkg::node_state_t       state_o,
  output logic [1:0]                 n_res_o,
  output tse_pkg::out_item_t [2:0]   res_o
);
  import tse_pkg::*;

  localparam out_item_t BLANK = '0;

  logic [31:0]        now_adj;
  logic [31:0]        age;
  logic [31:0]        t3_adj;
  logic [31:0]        t4_adj;
  logic signed [33:0] diff;
  logic signed [33:0] half;
  logic signed [7:0]  new_level;
  logic               sync_active;
  out_item_t [2:0]    res;
  logic [1:0]         n_res;

  // age since last sync with wrap correction
  always_comb begin
    now_adj = item_i.now;
    if (item_i.now < state_i.last_sync_time) begin
      now_adj = item_i.now + cfg_i.local_wrap_add;
    end
    age = now_adj - state_i.last_sync_time;
  end

  // offset from the four timestamps, halved toward zero
  always_comb begin
    t4_adj = (item_i.t1 > item_i.t4) ? item_i.t4 + cfg_i.exchange_wrap_add : item_i.t4;
    t3_adj = (item_i.t2 > item_i.t3) ? item_i.t3 + cfg_i.exchange_wrap_add : item_i.t3;
    diff   = ({{2{item_i.t2[31]}}, item_i.t2} - {{2{item_i.t1[31]}}, item_i.t1})
           - ({{2{t4_adj[31]}}, t4_adj} - {{2{t3_adj[31]}}, t3_adj});
    half   = (diff + {33'd0, diff[33]}) >>> 1;
  end

  assign new_level   = item_i.level_in + 8'sd1;
  assign sync_active = (state_i.sync_mode == MODE_SYNCING) ||
                       (state_i.sync_mode == MODE_INIT_SYNCING);

  // event decode
  always_comb begin
    state_o = state_i;
    res     = {BLANK, BLANK, BLANK};
    n_res   = 2'd0;
    case (item_i.kind)
      KIND_INIT: begin
        state_o.sync_mode      = MODE_INIT;
        state_o.tree_level     = -8'sd1;
        state_o.parent_addr    = '0;
        state_o.last_sync_time = '0;
        state_o.expected_seq   = '0;
        res[0].out_kind     = OK_ADVERT_BCAST;
        res[0].dest_addr    = BCAST_ADDR;
        res[0].level_out    = -8'sd1;
        res[1].out_kind     = OK_ADV_TIMER_START;
        res[1].timer_period = cfg_i.adv_period;
        n_res = 2'd2;
      end
      KIND_TIME_QUERY: begin
        if ((state_i.sync_mode == MODE_SYNCED) || (state_i.sync_mode == MODE_SYNCING)) begin
          if (state_i.tree_level == 8'sd1) begin
            res[0].out_kind    = OK_TIME_ANSWER;
            res[0].global_time = item_i.local_time;
            res[0].synced      = 1'b1;
            n_res = 2'd1;
          end else if ((state_i.sync_mode == MODE_SYNCED) && (age > cfg_i.resync_after)) begin
            state_o.sync_mode   = MODE_SYNCING;
            res[0].out_kind     = OK_SYNC_REQUEST;
            res[0].dest_addr    = state_i.parent_addr;
            res[0].seq_out      = state_i.expected_seq;
            res[1].out_kind     = OK_SYNC_TIMER_START;
            res[1].timer_period = cfg_i.sync_timeout;
            res[2].out_kind     = OK_TIME_ANSWER;
            res[2].global_time  = item_i.local_time + state_i.clock_offset;
            res[2].refreshed    = age;
            res[2].synced       = 1'b1;
            n_res = 2'd3;
          end else begin
            res[0].out_kind    = OK_TIME_ANSWER;
            res[0].global_time = item_i.local_time + state_i.clock_offset;
            res[0].refreshed   = age;
            res[0].synced      = 1'b1;
            n_res = 2'd1;
          end
        end else begin
          res[0].out_kind    = OK_TIME_ANSWER;
          res[0].global_time = cfg_i.not_synced_code;
          res[0].refreshed   = cfg_i.not_synced_code;
          n_res = 2'd1;
        end
      end
      KIND_TS_REQUEST: begin
        res[0].out_kind    = OK_TS_REPLY;
        res[0].dest_addr   = item_i.src_addr;
        res[0].seq_out     = item_i.seq_no;
        res[0].echo_first  = item_i.t1;
        res[0].echo_second = item_i.t2;
        n_res = 2'd1;
      end
      KIND_TS_REPLY: begin
        if (sync_active && (item_i.seq_no == state_i.expected_seq)) begin
          res[0].out_kind        = OK_SYNC_TIMER_STOP;
          state_o.expected_seq   = state_i.expected_seq + 8'd1;
          state_o.clock_offset   = half[31:0];
          state_o.last_sync_time = item_i.now;
          state_o.sync_mode      = MODE_SYNCED;
          n_res = 2'd1;
        end
      end
      KIND_ADV_TICK: begin
        if (state_i.sync_mode == MODE_INIT) begin
          res[0].out_kind  = OK_ADVERT_BCAST;
          res[0].dest_addr = BCAST_ADDR;
          res[0].level_out = state_i.tree_level;
          n_res = 2'd1;
        end
      end
      KIND_SYNC_TMO: begin
        if (sync_active) begin
          res[0].out_kind     = OK_SYNC_REQUEST;
          res[0].dest_addr    = state_i.parent_addr;
          res[0].seq_out      = state_i.expected_seq;
          res[1].out_kind     = OK_SYNC_TIMER_START;
          res[1].timer_period = cfg_i.sync_timeout;
          n_res = 2'd2;
        end
      end
      KIND_ADVERT: begin
        if ((state_i.sync_mode == MODE_SYNCED) && (state_i.tree_level < 8'sd2)) begin
          res[0].out_kind  = OK_LEVEL_REPLY;
          res[0].dest_addr = item_i.src_addr;
          res[0].level_out = state_i.tree_level;
          n_res = 2'd1;
        end
      end
      KIND_LEVEL_REPLY: begin
        if ((state_i.sync_mode == MODE_INIT) || (item_i.level_in < state_i.tree_level)) begin
          res[0].out_kind     = OK_ADV_TIMER_STOP;
          state_o.tree_level  = new_level;
          state_o.parent_addr = item_i.src_addr;
          if (new_level == 8'sd1) begin
            res[1].out_kind   = OK_LEVEL_REPLY;
            res[1].dest_addr  = item_i.src_addr;
            res[1].level_out  = new_level;
            state_o.sync_mode = MODE_SYNCED;
            n_res = 2'd2;
          end else begin
            state_o.sync_mode   = MODE_INIT_SYNCING;
            res[1].out_kind     = OK_SYNC_REQUEST;
            res[1].dest_addr    = item_i.src_addr;
            res[1].seq_out      = state_i.expected_seq;
            res[2].out_kind     = OK_SYNC_TIMER_START;
            res[2].timer_period = cfg_i.sync_timeout;
            n_res = 2'd3;
          end
        end
      end
      default: begin
      end
    endcase
    // flag the final beat of the event
    case (n_res)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  assign res_o   = res;
  assign n_res_o = n_res;

endmodule

`default_nettype wire

// ----- rtl/tpsn_time_sync_engine_core.sv -----
// top level of the two-way timestamp sync engine: input register, event logic, result queue
`default_nettype none

// Two-way timestamp time-sync engine. Each input beat is one protocol event
// (init, time query, timestamp request/reply, timer expiry, advert, level
// reply); it is captured in an input register, decoded combinationally against
// the protocol state, and its zero to three result beats are written into an
// eight-entry result queue. An event is accepted every cycle as long as the
// queue has at least three free entries; otherwise it waits in the input
// register. The output drains one beat per cycle while out_ready_i is high, so
// an event that produces k results occupies the output for k beats and the
// sustained rate is set by the total number of results. The last beat of each
// event has last set. Configuration registers are written through cfg_we_i /
// cfg_addr_i / cfg_wdata_i only while the engine is idle; the user must keep
// to this, as the block itself does not enforce it.
module tpsn_time_sync_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tse_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tse_pkg::out_item_t  out_item_o
);
  import tse_pkg::*;

  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  cfg_t            cfg_q;
  node_state_t     state_q, state_d;
  logic            in_vld_q;
  in_item_t        in_item_q;
  logic [1:0]      n_res;
  out_item_t [2:0] res;
  out_item_t       queue_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QAW:0]    cnt_q;
  logic            room;
  logic            fire;
  logic            pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resync_after      <= RST_RESYNC_AFTER;
      cfg_q.local_wrap_add    <= RST_LOCAL_WRAP_ADD;
      cfg_q.exchange_wrap_add <= RST_EXCHANGE_WRAP_ADD;
      cfg_q.not_synced_code   <= RST_NOT_SYNCED_CODE;
      cfg_q.sync_timeout      <= RST_SYNC_TIMEOUT;
      cfg_q.adv_period        <= RST_ADV_PERIOD;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_RESYNC_AFTER:      cfg_q.resync_after      <= cfg_wdata_i;
        REG_LOCAL_WRAP_ADD:    cfg_q.local_wrap_add    <= cfg_wdata_i;
        REG_EXCHANGE_WRAP_ADD: cfg_q.exchange_wrap_add <= cfg_wdata_i;
        REG_NOT_SYNCED_CODE:   cfg_q.not_synced_code   <= cfg_wdata_i;
        REG_SYNC_TIMEOUT:      cfg_q.sync_timeout      <= cfg_wdata_i[15:0];
        REG_ADV_PERIOD:        cfg_q.adv_period        <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // handshake control
  assign room        = (cnt_q <= (QAW+1)'(QDEPTH - MAX_RES));
  assign fire        = in_vld_q && room;
  assign in_ready_o  = !in_vld_q || room;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // event logic
  tse_step u_step (
    .item_i  (in_item_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .n_res_o (n_res),
    .res_o   (res)
  );

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.sync_mode      <= MODE_INIT;
      state_q.tree_level     <= -8'sd1;
      state_q.parent_addr    <= '0;
      state_q.clock_offset   <= '0;
      state_q.last_sync_time <= '0;
      state_q.expected_seq   <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < n_res) begin
          queue_q[wr_ptr_q + QAW'(i)] <= res[i];
        end
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_q <= wr_ptr_q + QAW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      cnt_q <= cnt_q + (fire ? (QAW+1)'(n_res) : '0) - (QAW+1)'(pop);
    end
  end

  assign out_item_o = queue_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- dv/tpsn_sync_checker.sv -----
// checker of the timestamp sync engine: event predictor and result comparison
`timescale 1ns / 1ps

module tpsn_sync_checker
  import tse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_item_i,
  output int         fail_cnt_o,
  output int         pending_o
);

  // register copies
  logic [31:0] cfg_refresh;
  logic [31:0] cfg_local_wrap;
  logic [31:0] cfg_xchg_wrap;
  logic [31:0] cfg_unsynced;
  logic [15:0] cfg_sync_tmo;
  logic [15:0] cfg_adv_period;

  // node protocol state
  mode_e             node_mode;
  logic signed [7:0] node_level;
  logic [15:0]       parent;
  logic [31:0]       offset;
  logic [31:0]       last_sync;
  logic [7:0]        seq_expected;

  // result beats still to come, oldest first
  out_item_t pending_beats[$];
  int        field_errs;
  out_item_t want;

  task queue_beat(input okind_e k, input logic [15:0] dest, input logic [7:0] lvl,
                  input logic [7:0] seq, input logic [31:0] gtime, input logic [31:0] age_v,
                  input logic [31:0] e1, input logic [31:0] e2, input logic [15:0] period,
                  input logic syn);
    out_item_t b;
    b = '0;
    b.out_kind     = k;
    b.dest_addr    = dest;
    b.level_out    = lvl;
    b.seq_out      = seq;
    b.global_time  = gtime;
    b.refreshed    = age_v;
    b.echo_first   = e1;
    b.echo_second  = e2;
    b.timer_period = period;
    b.synced       = syn;
    pending_beats.push_back(b);
  endtask

  // request to the parent plus the one-shot reply timer
  task queue_sync_request();
    queue_beat(OK_SYNC_REQUEST, parent, '0, seq_expected, '0, '0, '0, '0, '0, 1'b0);
    queue_beat(OK_SYNC_TIMER_START, '0, '0, '0, '0, '0, '0, '0, cfg_sync_tmo, 1'b0);
  endtask

  task automatic apply_sync_event(input in_item_t ev);
    int                start;
    logic [31:0]       cur, age, w3, w4;
    int                s1, s2, s3, s4;
    longint            diff, half;
    logic signed [7:0] lvl;
    out_item_t         b;
    start = pending_beats.size();
    lvl   = ev.level_in;
    case (ev.kind)
      KIND_INIT: begin
        node_mode    = MODE_INIT;
        node_level   = -8'sd1;
        parent       = '0;
        last_sync    = '0;
        seq_expected = '0;
        queue_beat(OK_ADVERT_BCAST, BCAST_ADDR, node_level, '0, '0, '0, '0, '0, '0, 1'b0);
        queue_beat(OK_ADV_TIMER_START, '0, '0, '0, '0, '0, '0, '0, cfg_adv_period, 1'b0);
      end
      KIND_TIME_QUERY: begin
        if (node_mode == MODE_SYNCED || node_mode == MODE_SYNCING) begin
          if (node_level == 8'sd1) begin
            queue_beat(OK_TIME_ANSWER, '0, '0, '0, ev.local_time, '0, '0, '0, '0, 1'b1);
          end else begin
            // age since last sync, with wrap of the local clock
            cur = ev.now;
            if (cur < last_sync) cur = cur + cfg_local_wrap;
            age = cur - last_sync;
            if (node_mode == MODE_SYNCED && age > cfg_refresh) begin
              node_mode = MODE_SYNCING;
              queue_sync_request();
            end
            queue_beat(OK_TIME_ANSWER, '0, '0, '0, ev.local_time + offset, age, '0, '0, '0,
                       1'b1);
          end
        end else begin
          queue_beat(OK_TIME_ANSWER, '0, '0, '0, cfg_unsynced, cfg_unsynced, '0, '0, '0,
                     1'b0);
        end
      end
      KIND_TS_REQUEST: begin
        queue_beat(OK_TS_REPLY, ev.src_addr, '0, ev.seq_no, '0, '0, ev.t1, ev.t2, '0, 1'b0);
      end
      KIND_TS_REPLY: begin
        if ((node_mode == MODE_SYNCING || node_mode == MODE_INIT_SYNCING) &&
            ev.seq_no == seq_expected) begin
          queue_beat(OK_SYNC_TIMER_STOP, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
          seq_expected = seq_expected + 8'd1;
          // wrap correction, then signed exact offset halved toward zero
          w3 = ev.t3;
          w4 = ev.t4;
          if (ev.t1 > w4) w4 = w4 + cfg_xchg_wrap;
          if (ev.t2 > w3) w3 = w3 + cfg_xchg_wrap;
          s1 = ev.t1;
          s2 = ev.t2;
          s3 = w3;
          s4 = w4;
          diff = (longint'(s2) - longint'(s1)) - (longint'(s4) - longint'(s3));
          half = diff / 2;
          offset    = half[31:0];
          last_sync = ev.now;
          node_mode = MODE_SYNCED;
        end
      end
      KIND_ADV_TICK: begin
        if (node_mode == MODE_INIT)
          queue_beat(OK_ADVERT_BCAST, BCAST_ADDR, node_level, '0, '0, '0, '0, '0, '0, 1'b0);
      end
      KIND_SYNC_TMO: begin
        if (node_mode == MODE_SYNCING || node_mode == MODE_INIT_SYNCING)
          queue_sync_request();
      end
      KIND_ADVERT: begin
        if (node_mode == MODE_SYNCED && node_level < 8'sd2)
          queue_beat(OK_LEVEL_REPLY, ev.src_addr, node_level, '0, '0, '0, '0, '0, '0, 1'b0);
      end
      KIND_LEVEL_REPLY: begin
        // join below the sender when unjoined or offered a lower level
        if (node_mode == MODE_INIT || lvl < node_level) begin
          queue_beat(OK_ADV_TIMER_STOP, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
          node_level = lvl + 8'sd1;
          parent     = ev.src_addr;
          if (node_level == 8'sd1) begin
            queue_beat(OK_LEVEL_REPLY, ev.src_addr, node_level, '0, '0, '0, '0, '0, '0, 1'b0);
            node_mode = MODE_SYNCED;
          end else begin
            node_mode = MODE_INIT_SYNCING;
            queue_sync_request();
          end
        end
      end
      default: ;
    endcase
    // mark the final beat of this event
    if (pending_beats.size() > start) begin
      b = pending_beats.pop_back();
      b.last = 1'b1;
      pending_beats.push_back(b);
    end
  endtask

  task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got);
    if (got !== exp_v) begin
      field_errs++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, got);
    end
  endtask

  // register writes, result comparison and prediction at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_refresh    = RST_RESYNC_AFTER;
      cfg_local_wrap = RST_LOCAL_WRAP_ADD;
      cfg_xchg_wrap  = RST_EXCHANGE_WRAP_ADD;
      cfg_unsynced   = RST_NOT_SYNCED_CODE;
      cfg_sync_tmo   = RST_SYNC_TIMEOUT;
      cfg_adv_period = RST_ADV_PERIOD;
      node_mode      = MODE_INIT;
      node_level     = -8'sd1;
      parent         = '0;
      offset         = '0;
      last_sync      = '0;
      seq_expected   = '0;
      pending_beats.delete();
      fail_cnt_o     = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_RESYNC_AFTER:      cfg_refresh    = cfg_wdata_i;
          REG_LOCAL_WRAP_ADD:    cfg_local_wrap = cfg_wdata_i;
          REG_EXCHANGE_WRAP_ADD: cfg_xchg_wrap  = cfg_wdata_i;
          REG_NOT_SYNCED_CODE:   cfg_unsynced   = cfg_wdata_i;
          REG_SYNC_TIMEOUT:      cfg_sync_tmo   = cfg_wdata_i[15:0];
          REG_ADV_PERIOD:        cfg_adv_period = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_beats.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: result beat expected none actual %h", $time, out_item_i);
        end else begin
          want = pending_beats.pop_front();
          field_errs = 0;
          check_field("out_kind", want.out_kind, out_item_i.out_kind);
          check_field("dest_addr", want.dest_addr, out_item_i.dest_addr);
          check_field("level_out", want.level_out, out_item_i.level_out);
          check_field("seq_out", want.seq_out, out_item_i.seq_out);
          check_field("global_time", want.global_time, out_item_i.global_time);
          check_field("refreshed", want.refreshed, out_item_i.refreshed);
          check_field("echo_first", want.echo_first, out_item_i.echo_first);
          check_field("echo_second", want.echo_second, out_item_i.echo_second);
          check_field("timer_period", want.timer_period, out_item_i.timer_period);
          check_field("synced", want.synced, out_item_i.synced);
          check_field("last", want.last, out_item_i.last);
          if (field_errs != 0) fail_cnt_o++;
        end
      end
      if (in_valid_i && in_ready_i) apply_sync_event(in_item_i);
      pending_o = pending_beats.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// top of the sync engine testbench: clock, reset, register setup and event stimulus
`timescale 1ns / 1ps

module testbench;
  import tse_pkg::*;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_item;

  int          fail_cnt;
  int          pending;
  int          items_sent = 0;
  int          stall_left = 0;
  bit          idling_on  = 1'b1;
  logic [31:0] node_clock = 32'd0;
  logic [7:0]  req_seq    = 8'd0;

  always #5 clk_i = ~clk_i;

  tpsn_time_sync_engine_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  tpsn_sync_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // receiver stalls in random bursts while idling_on is set
  always @(negedge clk_i) begin
    if (!idling_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // the requester answers its own latest sync request
  always @(posedge clk_i) begin
    if (out_valid && out_ready && out_item.out_kind == OK_SYNC_REQUEST)
      req_seq <= out_item.seq_out;
  end

  function automatic in_item_t random_event(input kind_e k);
    in_item_t e;
    e.kind       = k;
    e.now        = node_clock;
    e.local_time = $urandom;
    e.src_addr   = 16'($urandom);
    e.seq_no     = 8'($urandom);
    e.t1         = $urandom;
    e.t2         = $urandom;
    e.t3         = $urandom;
    e.t4         = $urandom;
    e.level_in   = 8'($urandom);
    return e;
  endfunction

  task send_event(input in_item_t e);
    int gap;
    int r;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= e;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    // local clock moves on, now and then by a lot or around the wrap
    r = $urandom_range(0, 15);
    if (r == 0) node_clock = node_clock + $urandom;
    else if (r < 3) node_clock = node_clock + $urandom_range(20000, 50000);
    else node_clock = node_clock + $urandom_range(1, 300);
  endtask

  // wait until every predicted beat is out and the engine is quiet
  task settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task write_reg(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task write_config(input logic [31:0] refresh, input logic [31:0] lwrap,
                    input logic [31:0] xwrap, input logic [31:0] unsynced,
                    input logic [31:0] tmo, input logic [31:0] adv);
    write_reg(REG_RESYNC_AFTER, refresh);
    write_reg(REG_LOCAL_WRAP_ADD, lwrap);
    write_reg(REG_EXCHANGE_WRAP_ADD, xwrap);
    write_reg(REG_NOT_SYNCED_CODE, unsynced);
    write_reg(REG_SYNC_TIMEOUT, tmo);
    write_reg(REG_ADV_PERIOD, adv);
  endtask

  // one join: init, adverts, level reply, then a mix of traffic around the exchange
  task run_session();
    in_item_t    e;
    int          r;
    logic [31:0] skew;
    logic [31:0] hop;
    send_event(random_event(KIND_INIT));
    repeat ($urandom_range(0, 2)) send_event(random_event(KIND_ADV_TICK));
    e = random_event(KIND_LEVEL_REPLY);
    r = $urandom_range(0, 99);
    if (r < 25) e.level_in = 8'sd0;
    else if (r < 85) e.level_in = 8'($urandom_range(1, 6));
    send_event(e);
    repeat ($urandom_range(4, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        e = random_event(KIND_TIME_QUERY);
      end else if (r < 45) begin
        e = random_event(KIND_TS_REQUEST);
      end else if (r < 55) begin
        e = random_event(KIND_SYNC_TMO);
      end else if (r < 62) begin
        e = random_event(KIND_ADV_TICK);
      end else if (r < 70) begin
        e = random_event(KIND_ADVERT);
      end else if (r < 90) begin
        if ($urandom_range(0, 1) == 1) settle();
        e = random_event(KIND_TS_REPLY);
        if ($urandom_range(0, 4) != 0) begin
          e.seq_no = req_seq;
          // plausible exchange: skewed clocks and a short flight time
          if ($urandom_range(0, 3) != 0) begin
            skew = $urandom_range(0, 2000) - 1000;
            hop  = $urandom_range(0, 500);
            e.t2 = e.t1 + skew + hop;
            e.t3 = e.t2 + $urandom_range(0, 50);
            e.t4 = e.t3 - skew + hop;
          end
        end
      end else begin
        e = random_event(KIND_LEVEL_REPLY);
      end
      send_event(e);
    end
  endtask

  task run_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) run_session();
  endtask

  initial begin
    in_item_t e;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unsynced node: query, advert tick, request extremes, ignored events
    send_event(random_event(KIND_TIME_QUERY));
    send_event(random_event(KIND_ADV_TICK));
    e = random_event(KIND_TS_REQUEST);
    e.src_addr = '1;
    e.seq_no   = '1;
    e.t1       = '1;
    e.t2       = '1;
    send_event(e);
    e = random_event(KIND_TS_REQUEST);
    e.src_addr = '0;
    e.seq_no   = '0;
    e.t1       = '0;
    e.t2       = '0;
    send_event(e);
    e = random_event(KIND_TS_REPLY);
    e.seq_no = 8'd0;
    send_event(e);
    send_event(random_event(KIND_SYNC_TMO));
    send_event(random_event(KIND_ADVERT));

    // join through the level wrap, then a level that is not lower
    e = random_event(KIND_LEVEL_REPLY);
    e.level_in = 8'sd127;
    send_event(e);
    e = random_event(KIND_LEVEL_REPLY);
    e.level_in = 8'h80;
    send_event(e);

    // stale reply, then a matching one with both timestamp wraps
    e = random_event(KIND_TS_REPLY);
    e.seq_no = 8'd1;
    send_event(e);
    e = random_event(KIND_TS_REPLY);
    e.seq_no = 8'd0;
    e.now    = 32'd1000;
    e.t1     = 32'hFFFF_FF00;
    e.t2     = 32'hFFFF_FFF0;
    e.t3     = 32'h0000_0020;
    e.t4     = 32'h0000_0010;
    send_event(e);

    // fresh query, local clock wrap forcing a resync, query while resyncing
    e = random_event(KIND_TIME_QUERY);
    e.now = 32'd1500;
    send_event(e);
    e = random_event(KIND_TIME_QUERY);
    e.now = 32'd10;
    send_event(e);
    e = random_event(KIND_TIME_QUERY);
    e.now = '1;
    send_event(e);
    send_event(random_event(KIND_SYNC_TMO));

    // signed extremes in the offset arithmetic
    e = random_event(KIND_TS_REPLY);
    e.seq_no = 8'd1;
    e.t1     = 32'h8000_0000;
    e.t2     = 32'h7FFF_FFFF;
    e.t3     = 32'h7FFF_FFFF;
    e.t4     = 32'hFFFF_FFFF;
    send_event(e);

    // level one node: level reply, advert answer, query passes time through
    send_event(random_event(KIND_INIT));
    e = random_event(KIND_LEVEL_REPLY);
    e.level_in = 8'sd0;
    send_event(e);
    send_event(random_event(KIND_ADVERT));
    send_event(random_event(KIND_TIME_QUERY));
    e = random_event(KIND_LEVEL_REPLY);
    e.level_in = -8'sd5;
    send_event(e);
    send_event(random_event(KIND_SYNC_TMO));
    send_event(random_event(KIND_INIT));
    settle();

    // random sessions under several register settings
    write_config('0, '0, '0, '0, '0, '0);
    run_phase(55);
    settle();
    write_config('1, '1, '1, '1, '1, '1);
    run_phase(55);
    settle();
    write_config($urandom_range(0, 60000), $urandom, $urandom, $urandom,
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_phase(55);
    settle();
    idling_on = 1'b0;
    write_config(RST_RESYNC_AFTER, RST_LOCAL_WRAP_ADD, RST_EXCHANGE_WRAP_ADD,
                 RST_NOT_SYNCED_CODE, 32'(RST_SYNC_TIMEOUT), 32'(RST_ADV_PERIOD));
    run_phase(55);
    settle();

    if (fail_cnt == 0) begin
      $display("[tpsn_time_sync_engine_core] OK");
    end else begin
      $display("[tpsn_time_sync_engine_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[tpsn_time_sync_engine_core] ERROR");
    $finish;
  end

endmodule
